### design/chg_pkg.sv
`timescale 1ns / 1ps

package chg_pkg;

  // Width of the floor square root of the approach distance, 2^-10 m.
  localparam int ROOT_W = 31;
  // Width of the quotient of the vertical cosine divide, Q15.16 magnitude.
  localparam int QUOT_W = 31;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DIST_GAIN  = 3'd0,
    REG_COS_TERM0  = 3'd1,
    REG_COS_TERM1  = 3'd2,
    REG_COS_TERM2  = 3'd3,
    REG_EFF_TAN    = 3'd4,
    REG_INV_LIGHT  = 3'd5,
    REG_INV_SIN    = 3'd6,
    REG_INV_TAN    = 3'd7
  } reg_idx_t;

  localparam logic [30:0] EFF_TAN_RST   = 31'd56252;
  localparam logic [30:0] INV_LIGHT_RST = 31'd218604;
  localparam logic [30:0] INV_SIN_RST   = 31'd100480;
  localparam logic [30:0] INV_TAN_RST   = 31'd76365;

  typedef struct packed {
    logic [31:0] gain;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [30:0] eff_tan;
    logic [30:0] inv_c;
    logic [30:0] inv_sin;
    logic [30:0] inv_tan;
  } cfg_t;

  // Item data that rides alongside the square root pipeline.
  typedef struct packed {
    logic [42:0] dtrack;
    logic [24:0] dz;
    logic [15:0] uz;
    logic [47:0] vt;
  } sqrt_sb_t;

  // Item data that rides alongside the divider pipeline.
  typedef struct packed {
    logic [47:0] arrival;
    logic [30:0] a;
    logic        ovf;
    logic        live;
    logic        neg;
  } div_sb_t;

endpackage

### design/chg_geom.sv
`timescale 1ns / 1ps

module chg_geom
  import chg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [23:0] sensor_x,
  input  logic [23:0] sensor_y,
  input  logic [23:0] sensor_z,
  input  logic [23:0] vertex_x,
  input  logic [23:0] vertex_y,
  input  logic [23:0] vertex_z,
  input  logic [15:0] dir_x,
  input  logic [15:0] dir_y,
  input  logic [15:0] dir_z,
  input  logic [47:0] vertex_time,
  output logic        out_vld,
  output logic [61:0] out_sq,
  output sqrt_sb_t    out_sb
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  logic signed [24:0] dx_r, dy_r, dz_r, dz2_r;
  logic signed [15:0] ux_r, uy_r, uz_r, uz2_r;
  logic [47:0]        vt1_r, vt2_r;

  logic signed [40:0] pxx_r, pyy_r, pzz_r;
  logic signed [40:0] pyz_r, pzy_r, pzx_r, pxz_r, pxy_r, pyx_r;

  logic signed [41:0] cx_r, cy_r, cz_r;
  logic signed [42:0] dtrack_nxt;
  logic [41:0]        cxm, cym, czm;
  logic [30:0]        ax_r, ay_r, az_r;
  logic [61:0]        sx_r, sy_r, sz_r, sq_r;
  sqrt_sb_t           sb3_r, sb4_r, sb5_r, sb6_r;

  assign dtrack_nxt = pxx_r + pyy_r + pzz_r;
  assign cxm = cx_r[41] ? 42'd0 - cx_r : cx_r;
  assign cym = cy_r[41] ? 42'd0 - cy_r : cy_r;
  assign czm = cz_r[41] ? 42'd0 - cz_r : cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    // Offset from vertex to sensor.
    dx_r  <= {sensor_x[23], sensor_x} - {vertex_x[23], vertex_x};
    dy_r  <= {sensor_y[23], sensor_y} - {vertex_y[23], vertex_y};
    dz_r  <= {sensor_z[23], sensor_z} - {vertex_z[23], vertex_z};
    ux_r  <= dir_x;
    uy_r  <= dir_y;
    uz_r  <= dir_z;
    vt1_r <= vertex_time;

    // All nine component products in parallel.
    pxx_r <= dx_r * ux_r;
    pyy_r <= dy_r * uy_r;
    pzz_r <= dz_r * uz_r;
    pyz_r <= dy_r * uz_r;
    pzy_r <= dz_r * uy_r;
    pzx_r <= dz_r * ux_r;
    pxz_r <= dx_r * uz_r;
    pxy_r <= dx_r * uy_r;
    pyx_r <= dy_r * ux_r;
    dz2_r <= dz_r;
    uz2_r <= uz_r;
    vt2_r <= vt1_r;

    cx_r  <= pyz_r - pzy_r;
    cy_r  <= pzx_r - pxz_r;
    cz_r  <= pxy_r - pyx_r;
    sb3_r <= '{dtrack: dtrack_nxt, dz: dz2_r, uz: uz2_r, vt: vt2_r};

    ax_r  <= cxm[40:10];
    ay_r  <= cym[40:10];
    az_r  <= czm[40:10];
    sb4_r <= sb3_r;

    sx_r  <= ax_r * ax_r;
    sy_r  <= ay_r * ay_r;
    sz_r  <= az_r * az_r;
    sb5_r <= sb4_r;

    sq_r  <= sx_r + sy_r + sz_r;
    sb6_r <= sb5_r;
  end

  assign out_vld = v6_r;
  assign out_sq  = sq_r;
  assign out_sb  = sb6_r;

endmodule

### design/chg_sqrt.sv
`timescale 1ns / 1ps

module chg_sqrt
  import chg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [61:0]         in_sq,
  input  sqrt_sb_t            in_sb,
  output logic                out_vld,
  output logic [ROOT_W-1:0]   out_root,
  output sqrt_sb_t            out_sb
);

  // One result bit per stage, most significant first.
  logic [62:0]       rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic              vld_r  [ROOT_W];
  sqrt_sb_t          sb_r   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int Bit = ROOT_W - 1 - k;
    logic [62:0]       rem_in, trial, rem_nxt;
    logic [ROOT_W-1:0] root_in, root_nxt;
    logic              vld_in;
    sqrt_sb_t          sb_in;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, in_sq};
      assign root_in = '0;
      assign vld_in  = in_vld;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign vld_in  = vld_r[k-1];
      assign sb_in   = sb_r[k-1];
    end

    always_comb begin
      trial = ({{(63-ROOT_W){1'b0}}, root_in} << (Bit + 1)) | (63'd1 << (2 * Bit));
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = root_in | ({{(ROOT_W-1){1'b0}}, 1'b1} << Bit);
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      sb_r[k]   <= sb_in;
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_sb   = sb_r[ROOT_W-1];

endmodule

### design/chg_time.sv
`timescale 1ns / 1ps

module chg_time
  import chg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [ROOT_W-1:0] in_a,
  input  sqrt_sb_t          in_sb,
  input  cfg_t              cfg,
  output logic              out_vld,
  output logic [59:0]       out_tz_mag,
  output logic [61:0]       out_travel,
  output div_sb_t           out_sb
);

  logic [7:0] vld_r;

  // Stage 1: products of the approach distance with the angle constants.
  logic [61:0] ma_r, mt_r, trav1_r;
  logic [30:0] a1_r;
  sqrt_sb_t    sb1_r;

  // Stage 2: path and distance to the emission point, 2^-20 m.
  logic [57:0] path_r, tov_r;
  logic [61:0] trav2_r;
  logic [30:0] a2_r;
  logic [24:0] dz2_r;
  logic [15:0] uz2_r;
  logic [47:0] vt2_r;

  // Stage 3: magnitudes and signs.
  logic [56:0] pmag_r, tmag_r;
  logic [15:0] umag_r;
  logic        pneg3_r, tneg3_r;
  logic [61:0] trav3_r;
  logic [30:0] a3_r;
  logic [24:0] dz3_r;
  logic [47:0] vt3_r;

  // Stage 4: partial products.
  logic [62:0] plo_r;
  logic [55:0] phi_r;
  logic [72:0] tprod_r;
  logic        pneg4_r, tneg4_r;
  logic [61:0] trav4_r;
  logic [30:0] a4_r;
  logic [24:0] dz4_r;
  logic [47:0] vt4_r;

  // Stage 5: partial products combined.
  logic [87:0] pfull;
  logic [57:0] dtmag_r;
  logic [58:0] ts_r;
  logic        pneg5_r, tneg5_r;
  logic [61:0] trav5_r;
  logic [30:0] a5_r;
  logic [24:0] dz5_r;
  logic [47:0] vt5_r;

  // Stage 6: signed time offset and vertical travel.
  logic [60:0] dz14, tsx;
  logic [58:0] dt_r;
  logic [60:0] tz_r;
  logic [61:0] trav6_r;
  logic [30:0] a6_r;
  logic [47:0] vt6_r;

  // Stage 7: arrival time, vertical travel magnitude.
  logic [59:0] arr_full;
  logic [47:0] arr_nxt, arr7_r;
  logic [59:0] tzmag7_r;
  logic        tzneg7_r;
  logic [61:0] trav7_r;
  logic [30:0] a7_r;

  // Stage 8: divider operands and flags.
  logic [59:0] tzmag8_r;
  logic [61:0] trav8_r;
  div_sb_t     sb8_r;

  assign pfull    = {phi_r, 32'd0} + {25'd0, plo_r};
  assign dz14     = {{22{dz5_r[24]}}, dz5_r, 14'd0};
  assign tsx      = {2'b00, ts_r};
  assign arr_full = {{12{vt6_r[47]}}, vt6_r} + {dt_r[58], dt_r};

  always_comb begin
    if (arr_full[59:47] == {13{arr_full[59]}}) begin
      arr_nxt = arr_full[47:0];
    end else if (arr_full[59]) begin
      arr_nxt = {1'b1, 47'd0};
    end else begin
      arr_nxt = {1'b0, {47{1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[6:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    ma_r    <= in_a * cfg.eff_tan;
    mt_r    <= in_a * cfg.inv_tan;
    trav1_r <= in_a * cfg.inv_sin;
    a1_r    <= in_a;
    sb1_r   <= in_sb;

    path_r  <= {{15{sb1_r.dtrack[42]}}, sb1_r.dtrack} + {2'b00, ma_r[61:6]};
    tov_r   <= {{15{sb1_r.dtrack[42]}}, sb1_r.dtrack} - {2'b00, mt_r[61:6]};
    trav2_r <= trav1_r;
    a2_r    <= a1_r;
    dz2_r   <= sb1_r.dz;
    uz2_r   <= sb1_r.uz;
    vt2_r   <= sb1_r.vt;

    pmag_r  <= path_r[57] ? 57'd0 - path_r[56:0] : path_r[56:0];
    tmag_r  <= tov_r[57] ? 57'd0 - tov_r[56:0] : tov_r[56:0];
    umag_r  <= uz2_r[15] ? 16'd0 - uz2_r : uz2_r;
    pneg3_r <= path_r[57];
    tneg3_r <= tov_r[57] ^ uz2_r[15];
    trav3_r <= trav2_r;
    a3_r    <= a2_r;
    dz3_r   <= dz2_r;
    vt3_r   <= vt2_r;

    plo_r   <= pmag_r[31:0] * cfg.inv_c;
    phi_r   <= pmag_r[56:32] * cfg.inv_c;
    tprod_r <= tmag_r * umag_r;
    pneg4_r <= pneg3_r;
    tneg4_r <= tneg3_r;
    trav4_r <= trav3_r;
    a4_r    <= a3_r;
    dz4_r   <= dz3_r;
    vt4_r   <= vt3_r;

    dtmag_r <= pfull[87:30];
    ts_r    <= tprod_r[72:14];
    pneg5_r <= pneg4_r;
    tneg5_r <= tneg4_r;
    trav5_r <= trav4_r;
    a5_r    <= a4_r;
    dz5_r   <= dz4_r;
    vt5_r   <= vt4_r;

    dt_r    <= pneg5_r ? 59'd0 - {1'b0, dtmag_r} : {1'b0, dtmag_r};
    tz_r    <= tneg5_r ? dz14 + tsx : dz14 - tsx;
    trav6_r <= trav5_r;
    a6_r    <= a5_r;
    vt6_r   <= vt5_r;

    arr7_r   <= arr_nxt;
    tzmag7_r <= tz_r[60] ? 60'd0 - tz_r[59:0] : tz_r[59:0];
    tzneg7_r <= tz_r[60];
    trav7_r  <= trav6_r;
    a7_r     <= a6_r;

    tzmag8_r      <= tzmag7_r;
    trav8_r       <= trav7_r;
    sb8_r.arrival <= arr7_r;
    sb8_r.a       <= a7_r;
    sb8_r.ovf     <= {11'd0, tzmag7_r} >= {trav7_r, 9'd0};
    sb8_r.live    <= (a7_r != '0) && (trav7_r != '0);
    sb8_r.neg     <= tzneg7_r;
  end

  assign out_vld    = vld_r[7];
  assign out_tz_mag = tzmag8_r;
  assign out_travel = trav8_r;
  assign out_sb     = sb8_r;

endmodule

### design/chg_div.sv
`timescale 1ns / 1ps

module chg_div
  import chg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [59:0]       in_tz_mag,
  input  logic [61:0]       in_travel,
  input  div_sb_t           in_sb,
  output logic              out_vld,
  output logic [QUOT_W-1:0] out_quot,
  output div_sb_t           out_sb
);

  // Restoring divide of tz_mag * 2^22 by travel, one quotient bit per stage.
  // The overflow flag covers quotients at or above 2^31, so the leading
  // partial remainder always lies below the divisor when the result is used.
  logic [61:0]       rem_r  [QUOT_W];
  logic [QUOT_W-1:0] num_r  [QUOT_W];
  logic [QUOT_W-1:0] quot_r [QUOT_W];
  logic [61:0]       den_r  [QUOT_W];
  logic              vld_r  [QUOT_W];
  div_sb_t           sb_r   [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic [61:0]       rem_in, den_in, rem_nxt;
    logic [62:0]       rem_sh;
    logic [QUOT_W-1:0] num_in, quot_in, quot_nxt;
    logic              vld_in;
    div_sb_t           sb_in;

    if (k == 0) begin : g_first
      assign rem_in  = {11'd0, in_tz_mag[59:9]};
      assign num_in  = {in_tz_mag[8:0], 22'd0};
      assign quot_in = '0;
      assign den_in  = in_travel;
      assign vld_in  = in_vld;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign num_in  = num_r[k-1];
      assign quot_in = quot_r[k-1];
      assign den_in  = den_r[k-1];
      assign vld_in  = vld_r[k-1];
      assign sb_in   = sb_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_in, num_in[QUOT_W-1]};
      if (rem_sh >= {1'b0, den_in}) begin
        rem_nxt  = rem_sh[61:0] - den_in;
        quot_nxt = {quot_in[QUOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[61:0];
        quot_nxt = {quot_in[QUOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      num_r[k]  <= {num_in[QUOT_W-2:0], 1'b0};
      quot_r[k] <= quot_nxt;
      den_r[k]  <= den_in;
      sb_r[k]   <= sb_in;
    end
  end

  assign out_vld  = vld_r[QUOT_W-1];
  assign out_quot = quot_r[QUOT_W-1];
  assign out_sb   = sb_r[QUOT_W-1];

endmodule

### design/chg_eff.sv
`timescale 1ns / 1ps

module chg_eff
  import chg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [QUOT_W-1:0] in_quot,
  input  div_sb_t           in_sb,
  input  cfg_t              cfg,
  output logic              out_vld,
  output logic [47:0]       out_arrival,
  output logic [31:0]       out_eff,
  output logic              out_on_track
);

  logic [7:0] vld_r;

  // Stage 1: cosine magnitude and coefficient magnitudes.
  logic [30:0] cmag_r, a1_r;
  logic        cneg_r;
  logic [31:0] t1mag_r, t2mag1_r;
  logic        t1neg_r, t2neg1_r;

  // Stage 2: first products.
  logic [61:0]        csq_r;
  logic [62:0]        t1p_r;
  logic signed [63:0] gp2_r;
  logic               t1sn2_r, t2neg2_r;
  logic [31:0]        t2mag2_r;

  // Stage 3: cosine squared split over two products.
  logic [62:0] t2lo_r, t2hi_r;
  logic [56:0] t1m_r;
  logic        t1sn3_r, t2neg3_r;
  logic [63:0] gp3_r;

  // Stage 4: capped squared term, signed linear cosine term.
  logic [93:0] t2full;
  logic [71:0] t2shift;
  logic [61:0] t2m_r;
  logic [63:0] t1s_r, gp4_r;
  logic        t2neg4_r;

  // Stages 5 to 8: sum, truncate to 1/64 m, clamp.
  logic [63:0] t2s_r, s1_r, sum_r;
  logic [42:0] smag_r;
  logic        sneg_r;
  logic [63:0] sabs;
  logic [31:0] eff_nxt, eff_r;

  logic [47:0] arr_r [8];
  logic        ot_r  [8];

  assign t2full  = {t2hi_r, 31'd0} + {31'd0, t2lo_r};
  assign t2shift = t2full[93:22];
  assign sabs    = sum_r[63] ? 64'd0 - sum_r : sum_r;

  always_comb begin
    if (!sneg_r) begin
      eff_nxt = (smag_r > 43'h0007FFFFFFF) ? 32'h7FFFFFFF : smag_r[31:0];
    end else begin
      eff_nxt = (smag_r > 43'h00080000000) ? 32'h80000000 : 32'd0 - smag_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[6:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    arr_r[0] <= in_sb.arrival;
    ot_r[0]  <= in_sb.a == '0;
    for (int i = 1; i < 8; i++) begin
      arr_r[i] <= arr_r[i-1];
      ot_r[i]  <= ot_r[i-1];
    end

    if (!in_sb.live) begin
      cmag_r <= '0;
    end else if (in_sb.ovf) begin
      cmag_r <= '1;
    end else begin
      cmag_r <= in_quot;
    end
    cneg_r   <= in_sb.live & in_sb.neg;
    a1_r     <= in_sb.a;
    t1mag_r  <= cfg.t1[31] ? 32'd0 - cfg.t1 : cfg.t1;
    t1neg_r  <= cfg.t1[31];
    t2mag1_r <= cfg.t2[31] ? 32'd0 - cfg.t2 : cfg.t2;
    t2neg1_r <= cfg.t2[31];

    csq_r    <= cmag_r * cmag_r;
    t1p_r    <= t1mag_r * cmag_r;
    gp2_r    <= $signed(cfg.gain) * $signed({1'b0, a1_r});
    t1sn2_r  <= t1neg_r ^ cneg_r;
    t2neg2_r <= t2neg1_r;
    t2mag2_r <= t2mag1_r;

    t2lo_r   <= t2mag2_r * csq_r[30:0];
    t2hi_r   <= t2mag2_r * csq_r[61:31];
    t1m_r    <= t1p_r[62:6];
    t1sn3_r  <= t1sn2_r;
    t2neg3_r <= t2neg2_r;
    gp3_r    <= gp2_r;

    // The squared term saturates at 2^61.
    t2m_r    <= (t2shift > (72'd1 << 61)) ? (62'd1 << 61) : t2shift[61:0];
    t1s_r    <= t1sn3_r ? 64'd0 - {7'd0, t1m_r} : {7'd0, t1m_r};
    gp4_r    <= gp3_r;
    t2neg4_r <= t2neg3_r;

    t2s_r    <= t2neg4_r ? 64'd0 - {2'd0, t2m_r} : {2'd0, t2m_r};
    s1_r     <= gp4_r + {{22{cfg.t0[31]}}, cfg.t0, 10'd0} + t1s_r;

    sum_r    <= s1_r + t2s_r;

    smag_r   <= sabs[62:20];
    sneg_r   <= sum_r[63];

    eff_r    <= eff_nxt;
  end

  assign out_vld      = vld_r[7];
  assign out_arrival  = arr_r[7];
  assign out_eff      = eff_r;
  assign out_on_track = ot_r[7];

endmodule

### design/cherenkov_hit_geometry.sv
`timescale 1ns / 1ps

// Cherenkov hit geometry. For each item (one sensor position against one
// track vertex, unit direction and vertex time) the block returns the
// expected direct-light arrival time in 1/64 ns, the ice-model effective
// distance in 1/64 m, and an on-track flag that is set when the closest
// approach distance is zero. The block takes a new item in every clock
// cycle: busy is never raised, so an item is accepted whenever start is
// high. Every item yields exactly one result, which is shown on the out_
// ports for a single cycle with out_valid high, in the order the items
// came in. The receiver cannot stall the block and must take each result
// in the cycle it appears. The pipeline depth is set by the two
// bit-per-stage units: the 31-stage square root that gives the approach
// distance and the 31-stage divider that gives the photon's vertical
// cosine; the remaining 22 stages hold the products and sums.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data and take effect at once; change them only while no item is in
// flight. The 31-bit registers take the low 31 bits of cfg_data.

module cherenkov_hit_geometry
  import chg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_sensor_x,
  input  logic [23:0] in_sensor_y,
  input  logic [23:0] in_sensor_z,
  input  logic [23:0] in_vertex_x,
  input  logic [23:0] in_vertex_y,
  input  logic [23:0] in_vertex_z,
  input  logic [15:0] in_dir_x,
  input  logic [15:0] in_dir_y,
  input  logic [15:0] in_dir_z,
  input  logic [47:0] in_vertex_time,

  output logic        out_valid,
  output logic [47:0] out_arrival_time,
  output logic [31:0] out_effective_dist,
  output logic        out_on_track,

  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;

  logic              geom_vld;
  logic [61:0]       geom_sq;
  sqrt_sb_t          geom_sb;

  logic              sqrt_vld;
  logic [ROOT_W-1:0] sqrt_root;
  sqrt_sb_t          sqrt_sb;

  logic              time_vld;
  logic [59:0]       time_tz_mag;
  logic [61:0]       time_travel;
  div_sb_t           time_sb;

  logic              div_vld;
  logic [QUOT_W-1:0] div_quot;
  div_sb_t           div_sb;

  // The pipeline never holds an item back.
  assign busy = 1'b0;

  // Configuration registers.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DIST_GAIN: cfg_nxt.gain    = cfg_data;
        REG_COS_TERM0: cfg_nxt.t0      = cfg_data;
        REG_COS_TERM1: cfg_nxt.t1      = cfg_data;
        REG_COS_TERM2: cfg_nxt.t2      = cfg_data;
        REG_EFF_TAN:   cfg_nxt.eff_tan = cfg_data[30:0];
        REG_INV_LIGHT: cfg_nxt.inv_c   = cfg_data[30:0];
        REG_INV_SIN:   cfg_nxt.inv_sin = cfg_data[30:0];
        REG_INV_TAN:   cfg_nxt.inv_tan = cfg_data[30:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain    <= '0;
      cfg_r.t0      <= '0;
      cfg_r.t1      <= '0;
      cfg_r.t2      <= '0;
      cfg_r.eff_tan <= EFF_TAN_RST;
      cfg_r.inv_c   <= INV_LIGHT_RST;
      cfg_r.inv_sin <= INV_SIN_RST;
      cfg_r.inv_tan <= INV_TAN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Offset, dot product, cross product and the sum of squared cross
  // components: six stages.
  chg_geom u_geom (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (start & ~busy),
    .sensor_x    (in_sensor_x),
    .sensor_y    (in_sensor_y),
    .sensor_z    (in_sensor_z),
    .vertex_x    (in_vertex_x),
    .vertex_y    (in_vertex_y),
    .vertex_z    (in_vertex_z),
    .dir_x       (in_dir_x),
    .dir_y       (in_dir_y),
    .dir_z       (in_dir_z),
    .vertex_time (in_vertex_time),
    .out_vld     (geom_vld),
    .out_sq      (geom_sq),
    .out_sb      (geom_sb)
  );

  // Approach distance as the floor square root, one bit per stage.
  chg_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (geom_vld),
    .in_sq    (geom_sq),
    .in_sb    (geom_sb),
    .out_vld  (sqrt_vld),
    .out_root (sqrt_root),
    .out_sb   (sqrt_sb)
  );

  // Arrival time and the divider operands for the vertical cosine:
  // eight stages.
  chg_time u_time (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (sqrt_vld),
    .in_a       (sqrt_root),
    .in_sb      (sqrt_sb),
    .cfg        (cfg_r),
    .out_vld    (time_vld),
    .out_tz_mag (time_tz_mag),
    .out_travel (time_travel),
    .out_sb     (time_sb)
  );

  // Vertical cosine magnitude, one quotient bit per stage.
  chg_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (time_vld),
    .in_tz_mag  (time_tz_mag),
    .in_travel  (time_travel),
    .in_sb      (time_sb),
    .out_vld    (div_vld),
    .out_quot   (div_quot),
    .out_sb     (div_sb)
  );

  // Ice-model polynomial, truncation and saturation: eight stages ending
  // in the output registers.
  chg_eff u_eff (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (div_vld),
    .in_quot      (div_quot),
    .in_sb        (div_sb),
    .cfg          (cfg_r),
    .out_vld      (out_valid),
    .out_arrival  (out_arrival_time),
    .out_eff      (out_effective_dist),
    .out_on_track (out_on_track)
  );

endmodule
